[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is asserted.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bls_pkg.sv]
package bls_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

endpackage

[sv/bls_front.sv]
module bls_front #(
    parameter int COORD_BITS = 12
) (
    input  bls_pkg::op_t                  op,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by,
    // Fields from the lowest bit up: op, x_neg, start_x, start_y, abs_dx, dy.
    output logic [4*COORD_BITS+1:0]       entry
);
    import bls_pkg::*;

    logic                         swap;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [COORD_BITS:0]   dx_pos;
    logic signed [COORD_BITS:0]   dx_neg;
    logic signed [COORD_BITS:0]   dy_w;
    logic                         x_neg;
    logic [COORD_BITS-1:0]        abs_dx;

    // Trace from the endpoint with the smaller y, or the smaller x on a tie.
    assign swap = !((ay < by) || ((ay == by) && (ax <= bx)));

    always_comb begin
        if (swap) begin
            sx = bx;
            sy = by;
            ex = ax;
            ey = ay;
        end else begin
            sx = ax;
            sy = ay;
            ex = bx;
            ey = by;
        end
    end

    // Both signs of the x difference are formed side by side so the
    // magnitude needs no negation after the subtract.
    assign dx_pos = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    assign dx_neg = {sx[COORD_BITS-1], sx} - {ex[COORD_BITS-1], ex};
    assign dy_w   = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
    assign x_neg  = dx_pos[COORD_BITS];
    assign abs_dx = x_neg ? dx_neg[COORD_BITS-1:0] : dx_pos[COORD_BITS-1:0];

    assign entry = {dy_w[COORD_BITS-1:0], abs_dx, sy, sx, x_neg, op};

endmodule

[sv/bls_queue.sv]
module bls_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/bls_back.sv]
module bls_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [4*COORD_BITS+1:0]      in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] px,
    output logic signed [COORD_BITS-1:0] py,
    output logic                         last
);
    import bls_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int EB   = COORD_BITS + 3;
    localparam int REMB = COORD_BITS + 1;

    op_t                  cmd_op;
    logic                 cmd_x_neg;
    logic [CB-1:0]        cmd_sx;
    logic [CB-1:0]        cmd_sy;
    logic [CB-1:0]        cmd_adx;
    logic [CB-1:0]        cmd_dy;

    logic [CB-1:0]        major_pos_reg;
    logic [CB-1:0]        major_pos_next;
    logic [CB-1:0]        minor_pos_reg;
    logic [CB-1:0]        minor_pos_next;
    logic signed [EB-1:0] err_reg;
    logic signed [EB-1:0] err_next;
    logic signed [EB-1:0] inc_flat_reg;
    logic signed [EB-1:0] inc_flat_next;
    logic signed [EB-1:0] inc_diag_reg;
    logic signed [EB-1:0] inc_diag_next;
    logic [REMB-1:0]      remaining_reg;
    logic [REMB-1:0]      remaining_next;
    logic                 major_is_y_reg;
    logic                 major_is_y_next;
    logic                 x_neg_reg;
    logic                 x_neg_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CB-1:0]        px_reg;
    logic [CB-1:0]        px_next;
    logic [CB-1:0]        py_reg;
    logic [CB-1:0]        py_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 take;
    logic                 y_major;
    logic [CB-1:0]        dmaj;
    logic [CB-1:0]        dmin;
    logic signed [EB-1:0] dmaj_w;
    logic signed [EB-1:0] dmin_w;
    logic [CB-1:0]        major_step;
    logic [CB-1:0]        minor_step;
    logic                 major_dec;
    logic                 minor_dec;

    assign cmd_op    = op_t'(in_data[0]);
    assign cmd_x_neg = in_data[1];
    assign cmd_sx    = in_data[2 +: CB];
    assign cmd_sy    = in_data[2 + CB +: CB];
    assign cmd_adx   = in_data[2 + 2*CB +: CB];
    assign cmd_dy    = in_data[2 + 3*CB +: CB];

    // The output word can be replaced whenever it is empty or being taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign y_major = (cmd_dy > cmd_adx);
    assign dmaj    = y_major ? cmd_dy : cmd_adx;
    assign dmin    = y_major ? cmd_adx : cmd_dy;
    assign dmaj_w  = EB'(dmaj);
    assign dmin_w  = EB'(dmin);

    assign major_dec  = !major_is_y_reg && x_neg_reg;
    assign minor_dec  = major_is_y_reg && x_neg_reg;
    assign major_step = major_dec ? major_pos_reg - 1'b1 : major_pos_reg + 1'b1;
    assign minor_step = minor_dec ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;

    always_comb begin
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        err_next        = err_reg;
        inc_flat_next   = inc_flat_reg;
        inc_diag_next   = inc_diag_reg;
        remaining_next  = remaining_reg;
        major_is_y_next = major_is_y_reg;
        x_neg_next      = x_neg_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        last_next       = last_reg;
        out_valid_next  = in_ready ? 1'b0 : out_valid_reg;
        if (take) begin
            unique case (cmd_op)
                OP_LOAD: begin
                    major_is_y_next = y_major;
                    x_neg_next      = cmd_x_neg;
                    major_pos_next  = y_major ? cmd_sy : cmd_sx;
                    minor_pos_next  = y_major ? cmd_sx : cmd_sy;
                    // The two error increments are fixed for the segment, so
                    // they are formed once here and each step needs one add.
                    err_next        = (dmin_w <<< 1) - dmaj_w;
                    inc_flat_next   = dmin_w <<< 1;
                    inc_diag_next   = (dmin_w <<< 1) - (dmaj_w <<< 1);
                    remaining_next  = REMB'(dmaj);
                end
                OP_STEP: begin
                    if (remaining_reg != '0) begin
                        major_pos_next = major_step;
                        if (err_reg > 0) begin
                            minor_pos_next = minor_step;
                            err_next       = err_reg + inc_diag_reg;
                        end else begin
                            err_next       = err_reg + inc_flat_reg;
                        end
                        remaining_next = remaining_reg - 1'b1;
                        out_valid_next = 1'b1;
                        last_next      = (remaining_reg == REMB'(1));
                        if (major_is_y_reg) begin
                            px_next = (err_reg > 0) ? minor_step : minor_pos_reg;
                            py_next = major_step;
                        end else begin
                            px_next = major_step;
                            py_next = (err_reg > 0) ? minor_step : minor_pos_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            err_reg        <= '0;
            inc_flat_reg   <= '0;
            inc_diag_reg   <= '0;
            remaining_reg  <= '0;
            major_is_y_reg <= 1'b0;
            x_neg_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            major_pos_reg  <= major_pos_next;
            minor_pos_reg  <= minor_pos_next;
            err_reg        <= err_next;
            inc_flat_reg   <= inc_flat_next;
            inc_diag_reg   <= inc_diag_next;
            remaining_reg  <= remaining_next;
            major_is_y_reg <= major_is_y_next;
            x_neg_reg      <= x_neg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign px        = px_reg;
    assign py        = py_reg;
    assign last      = last_reg;

endmodule

[sv/bresenham_line_stepper.sv]
// Integer line rasterizer for all octants.
// Input channel (s_): s_tuser selects the command, 0 loads a segment and 1
// asks for the next pixel. s_tdata carries ax, ay, bx, by from the lowest bit
// up; the endpoints are only looked at on a load. A load emits no word.
// Output channel (m_): m_tdata carries px, py from the lowest bit up, and
// m_tlast marks the far endpoint. A step with no pixels left emits no word.
// A small command queue sits between the input decoder and the stepper.
// A step word passes through the queue and then the output register before
// it shows on m_tvalid. One command is taken per cycle while m_tready stays
// high, so pixels leave at one per clock when step commands keep arriving;
// the stepper's error update, a single add per step, sets that rate.
// When the receiver stalls, the output word holds and the queue fills;
// s_tready drops once the queue is full. The queue depth defaults to two.
// Synchronous reset clears the queue, the output valid flag and the stepper
// state, leaving the block idle with no segment loaded.
module bresenham_line_stepper #(
    parameter int COORD_BITS  = bls_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // ax, ay, bx, by from the lowest bit up, zero padded to whole bytes.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // operation.
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // px, py from the lowest bit up, zero padded to whole bytes.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                  m_tlast
);
    import bls_pkg::*;

    localparam int ENTRY_W = 4*COORD_BITS + 2;
    localparam int M_W     = ((2*COORD_BITS+7)/8)*8;

    logic [ENTRY_W-1:0]          push_entry;
    logic [ENTRY_W-1:0]          pop_entry;
    logic                        pop_valid;
    logic                        pop_ready;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;

    bls_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .op    (op_t'(s_tuser[0])),
        .ax    (s_tdata[0 +: COORD_BITS]),
        .ay    (s_tdata[COORD_BITS +: COORD_BITS]),
        .bx    (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .by    (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .entry (push_entry)
    );

    bls_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    bls_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_data   (pop_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .px        (px),
        .py        (py),
        .last      (m_tlast)
    );

    assign m_tdata = M_W'({py, px});

endmodule

[sv/bls_checker.sv]
`include "assert_macros.svh"

module bls_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input logic                              m_tlast
);

    // Reset leaves no pixel word pending.
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // A stalled pixel word keeps its contents.
    `ASSERT_CLKD(a_stall_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled output changed")

    // The queue can only be full if the stepper was held by a stall on the
    // previous cycle, since it drains one command per cycle otherwise.
    `ASSERT_CLKD(a_full_needs_stall, aclk, aresetn,
        !s_tready |-> $past(m_tvalid) && $past(!m_tready),
        "input blocked without output stall")

endmodule

bind bresenham_line_stepper bls_checker #(
    .COORD_BITS(COORD_BITS)
) u_bls_checker (.*);
